// ===== hw/rtl/fpq_pkg.sv =====
// Shared types, constants and action codes for the Q24.8 fixed-point ALU.
// No dependencies.
package fpq_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_BITS     = 32;
    localparam int DATA_BITS     = 32;
    localparam int QUOT_BITS     = WORD_BITS + FRACTION_BITS;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_LT       = 4'd5,
        ACT_GE       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_MIN      = 4'd10,
        ACT_MAX      = 4'd11,
        ACT_INC      = 4'd12,
        ACT_FROM_INT = 4'd13,
        ACT_TO_INT   = 4'd14
    } action_t;

    // One item in flight along the divider chain
    typedef struct packed {
        logic                   valid;
        logic                   is_div;
        logic                   neg;
        logic                   dz;
        logic                   cmp;
        logic [WORD_BITS-1:0]   res;
        logic [WORD_BITS-1:0]   bmag;
        logic [WORD_BITS-1:0]   rem;
        logic [QUOT_BITS-1:0]   dq;
    } item_t;

endpackage

// ===== hw/rtl/fpq_front.sv =====
// Operand decode: computes all non-divide results and sets up the divider.
// Depends on fpq_pkg.
module fpq_front (
    input  logic                        valid,
    input  logic [3:0]                  action,
    input  logic [fpq_pkg::DATA_BITS-1:0] operand_a,
    input  logic [fpq_pkg::DATA_BITS-1:0] operand_b,
    output fpq_pkg::item_t              item
);

    localparam int W = fpq_pkg::WORD_BITS;
    localparam int F = fpq_pkg::FRACTION_BITS;

    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] prod_sh;
    logic [W-1:0]          amag;

    assign a       = $signed(operand_a[W-1:0]);
    assign b       = $signed(operand_b[W-1:0]);
    assign prod    = a * b;
    assign prod_sh = prod >>> F;
    assign amag    = a[W-1] ? W'(-a) : W'(a);

    // Decode the action and form the result word
    always_comb
    begin
        item        = '0;
        item.valid  = valid;
        item.bmag   = b[W-1] ? W'(-b) : W'(b);
        item.rem    = '0;
        item.dq     = {amag, {F{1'b0}}};
        item.neg    = a[W-1] ^ b[W-1];
        unique case (action)
            fpq_pkg::ACT_ADD:      item.res = W'(a + b);
            fpq_pkg::ACT_SUB:      item.res = W'(a - b);
            fpq_pkg::ACT_MUL:      item.res = prod_sh[W-1:0];
            fpq_pkg::ACT_DIV:
            begin
                item.is_div = 1'b1;
                item.dz     = (b == '0);
            end
            fpq_pkg::ACT_GT:       item.cmp = (a > b);
            fpq_pkg::ACT_LT:       item.cmp = (a < b);
            fpq_pkg::ACT_GE:       item.cmp = (a >= b);
            fpq_pkg::ACT_LE:       item.cmp = (a <= b);
            fpq_pkg::ACT_EQ:       item.cmp = (a == b);
            fpq_pkg::ACT_NE:       item.cmp = (a != b);
            fpq_pkg::ACT_MIN:      item.res = (a < b) ? a : b;
            fpq_pkg::ACT_MAX:      item.res = (a > b) ? a : b;
            fpq_pkg::ACT_INC:      item.res = W'(a + 1);
            fpq_pkg::ACT_FROM_INT: item.res = W'(a <<< F);
            fpq_pkg::ACT_TO_INT:   item.res = W'(a >>> F);
            default:               item.res = '0;
        endcase
    end

endmodule

// ===== hw/rtl/fpq_cell.sv =====
// One restoring-division cell: settles one quotient bit and registers the item.
// Depends on fpq_pkg.
module fpq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  fpq_pkg::item_t item_in,
    output fpq_pkg::item_t item_out
);

    localparam int W = fpq_pkg::WORD_BITS;
    localparam int Q = fpq_pkg::QUOT_BITS;

    fpq_pkg::item_t item_reg;
    fpq_pkg::item_t item_next;
    logic [W-1:0]   trial;
    logic           ge;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial     = {item_in.rem[W-2:0], item_in.dq[Q-1]};
        ge        = (trial >= item_in.bmag);
        item_next = item_in;
        item_next.rem = ge ? W'(trial - item_in.bmag) : trial;
        item_next.dq  = {item_in.dq[Q-2:0], ge};
    end

    // Clear the item under reset; advance the whole item together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu.sv =====
// Top level of the Q24.8 fixed-point ALU: decode, divider cell chain, output register.
// Depends on fpq_pkg, fpq_front and fpq_cell.
// Stages: one registered cell per quotient bit of the Q24.8 result, plus the output stage.
// Throughput: one item per cycle; the whole chain advances unless the output is stalled.
// Reset: rst_n clears all valid bits asynchronously; no item is in flight after reset.
module fixed_point_q24_8_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [3:0]                    action,
    input  logic [fpq_pkg::DATA_BITS-1:0] operand_a,
    input  logic [fpq_pkg::DATA_BITS-1:0] operand_b,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [fpq_pkg::DATA_BITS-1:0] result_raw,
    output logic                          compare_true,
    output logic                          divide_by_zero
);

    localparam int W = fpq_pkg::WORD_BITS;
    localparam int Q = fpq_pkg::QUOT_BITS;
    localparam int D = fpq_pkg::DATA_BITS;

    logic           advance;
    fpq_pkg::item_t chain [0:Q];
    fpq_pkg::item_t last;
    logic [Q-1:0]   qsign;
    logic [W-1:0]   res_final;

    logic           valid_reg;
    logic [D-1:0]   res_reg;
    logic           cmp_reg;
    logic           dz_reg;

    // Advance everything unless a finished item is held at the output
    assign advance    = !valid_reg || !result_stall;
    assign item_stall = !advance;

    fpq_front u_front (
        .valid     (item_valid),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .item      (chain[0])
    );

    // Build the division chain, one cell per quotient bit
    for (genvar i = 0; i < Q; i++)
    begin : g_cell
        fpq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    // Apply the quotient sign and select the final word
    assign last  = chain[Q];
    assign qsign = last.neg ? Q'(-last.dq) : last.dq;

    always_comb
    begin
        if (last.is_div)
        begin
            res_final = last.dz ? '0 : qsign[W-1:0];
        end
        else
        begin
            res_final = last.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= D'($signed(res_final));
            cmp_reg <= last.cmp;
            dz_reg  <= last.is_div && last.dz;
        end
    end

    assign result_valid   = valid_reg;
    assign result_raw     = res_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

    // A zero divisor always yields a zero word
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && dz_reg) |-> (res_reg == '0))
        else $error("divide by zero with nonzero result");

    // A comparison that comes out true yields a zero word and never flags divide by zero
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cmp_reg) |-> (res_reg == '0 && !dz_reg))
        else $error("comparison with nonzero result or error flag");

    // A held output item stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_stall) |=> (valid_reg && $stable(res_reg)))
        else $error("stalled item changed");

    // Input stalls only when the output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (valid_reg && result_stall))
        else $error("input stalled without output hold");

endmodule
